// ===== sv/u2r_pkg.sv =====
// shared types, constants and helpers for the radix digit converter
// no dependencies; imported by every module of the block
package u2r_pkg;

  localparam int VALUE_WIDTH_DEF = 64;
  localparam int VAL_W           = 64;
  localparam int RADIX_W         = 6;
  localparam int DIGIT_W         = 6;
  localparam int CHAR_W          = 7;
  localparam int COUNT_W         = 7;
  localparam int DIGIT_DEPTH     = 64;
  localparam int ADDR_W          = $clog2(DIGIT_DEPTH);

  localparam logic [RADIX_W-1:0] RADIX_MIN      = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX      = 6'd36;
  localparam logic [DIGIT_W-1:0] DECIMAL_DIGITS = 6'd10;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO      = 7'd48;
  localparam logic [CHAR_W-1:0]  CHAR_LETTER_A  = 7'd65;

  typedef struct packed {
    logic [VAL_W-1:0]   value;
    logic [RADIX_W-1:0] radix;
  } in_word_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  digit_char;
    logic [COUNT_W-1:0] digit_count;
    logic               last;
  } out_word_t;

  // write port of the digit store
  typedef struct packed {
    logic               en;
    logic [ADDR_W-1:0]  addr;
    logic [DIGIT_W-1:0] data;
  } store_wr_t;

  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] c;
    c = r;
    if (r < RADIX_MIN) c = RADIX_MIN;
    if (r > RADIX_MAX) c = RADIX_MAX;
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] ch;
    if (d < DECIMAL_DIGITS) begin
      ch = CHAR_ZERO + {1'b0, d};
    end else begin
      ch = CHAR_LETTER_A + {1'b0, d - DECIMAL_DIGITS};
    end
    return ch;
  endfunction

endpackage

// ===== sv/u2r_div.sv =====
// bit-serial restoring divider: VALUE_WIDTH-bit dividend by a small radix
// depends on u2r_pkg
module u2r_div import u2r_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  logic [RADIX_W-1:0]     radix,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] quotient,
  output logic [DIGIT_W-1:0]     remainder
);

  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

  logic                   run;
  logic [CNT_W-1:0]       cnt;
  logic [VALUE_WIDTH-1:0] quo;
  logic [DIGIT_W-1:0]     rem;
  logic [RADIX_W-1:0]     div_radix;

  logic [DIGIT_W:0]       trial;
  logic                   fits;

  assign trial = {rem, quo[VALUE_WIDTH-1]};
  assign fits  = trial >= {1'b0, div_radix};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= run && (cnt == CNT_W'(1));
      if (start) begin
        run <= 1'b1;
      end else if (run && (cnt == CNT_W'(1))) begin
        run <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo       <= dividend;
      rem       <= '0;
      cnt       <= CNT_W'(VALUE_WIDTH);
      div_radix <= radix;
    end else if (run) begin
      quo <= {quo[VALUE_WIDTH-2:0], fits};
      rem <= fits ? DIGIT_W'(trial - {1'b0, div_radix}) : trial[DIGIT_W-1:0];
      cnt <= cnt - CNT_W'(1);
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

// ===== sv/u2r_store.sv =====
// digit store: one write port, one read port with registered read data
// depends on u2r_pkg
module u2r_store import u2r_pkg::*; (
  input  logic               clk,
  input  store_wr_t          wr,
  input  logic               rd_en,
  input  logic [ADDR_W-1:0]  rd_addr,
  output logic [DIGIT_W-1:0] rd_data
);

  logic [DIGIT_W-1:0] mem [DIGIT_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/unsigned_to_radix_digits_top.sv =====
// unsigned to radix digit converter, top level; uses u2r_pkg, u2r_div, u2r_store
// divide phase: digits are divided out one at a time, least significant first;
//   read phase: one digit word per cycle, most significant first
// one value at a time, paced by the one-bit-per-cycle divider; results
//   cannot be stalled
// reset: synchronous, clears the controller, strobe and stored digit count
module unsigned_to_radix_digits_top import u2r_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  in_word_t  operand,
  output logic      strobe,
  output out_word_t result
);

  // controller states
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_READ = 3'b100
  } state_t;

  state_t state, state_next;

  // digit counters
  logic [COUNT_W-1:0] n, n_next;        // digits divided out so far
  logic [COUNT_W-1:0] k, k_next;        // digits read back so far
  logic [COUNT_W-1:0] held, held_next;  // digits in the store

  // clamped radix of the word in flight; the operand may change once accepted
  logic [RADIX_W-1:0] radix_held, radix_held_next;

  // read pipeline, aligned with the store's registered read data
  logic               rd_valid, rd_valid_next;
  logic               rd_last, rd_last_next;
  logic [COUNT_W-1:0] rd_count, rd_count_next;

  logic                   div_start;
  logic [VALUE_WIDTH-1:0] div_dividend;
  logic [RADIX_W-1:0]     div_radix;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] div_quo;
  logic [DIGIT_W-1:0]     div_rem;

  store_wr_t          st_wr;
  logic               st_rd_en;
  logic [ADDR_W-1:0]  st_rd_addr;
  logic [DIGIT_W-1:0] st_rd_data;
  logic [COUNT_W-1:0] rd_index;

  // divider: one quotient bit per cycle, restarted on its own quotient
  u2r_div #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .radix     (div_radix),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // remainders land least significant first; writes happen only in the divide
  // phase and reads only after it, so the same entry never overlaps
  u2r_store u_store (
    .clk     (clk),
    .wr      (st_wr),
    .rd_en   (st_rd_en),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data)
  );

  assign busy = (state != S_IDLE);

  // most significant digit sits at the highest written entry
  assign rd_index   = held - COUNT_W'(1) - k;
  assign st_rd_addr = rd_index[ADDR_W-1:0];

  always_comb begin
    state_next      = state;
    n_next          = n;
    k_next          = k;
    held_next       = held;
    radix_held_next = radix_held;
    rd_valid_next   = 1'b0;
    rd_last_next    = 1'b0;
    rd_count_next   = rd_count;
    div_start       = 1'b0;
    div_dividend    = div_quo;
    div_radix       = radix_held;
    st_wr.en        = 1'b0;
    st_wr.addr      = n[ADDR_W-1:0];
    st_wr.data      = div_rem;
    st_rd_en        = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          // high bits above the configured width are dropped
          div_dividend    = operand.value[VALUE_WIDTH-1:0];
          div_radix       = clamp_radix(operand.radix);
          radix_held_next = clamp_radix(operand.radix);
          div_start       = 1'b1;
          n_next          = '0;
          state_next      = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          st_wr.en = 1'b1;
          n_next   = n + COUNT_W'(1);
          if ((div_quo == '0) || (n == COUNT_W'(DIGIT_DEPTH - 1))) begin
            held_next  = n + COUNT_W'(1);
            k_next     = '0;
            state_next = S_READ;
          end else begin
            // keep dividing the quotient
            div_start = 1'b1;
          end
        end
      end
      S_READ: begin
        st_rd_en      = 1'b1;
        rd_valid_next = 1'b1;
        rd_count_next = held;
        rd_last_next  = (k == held - COUNT_W'(1));
        k_next        = k + COUNT_W'(1);
        if (k == held - COUNT_W'(1)) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      held     <= '0;
      rd_valid <= 1'b0;
    end else begin
      state    <= state_next;
      held     <= held_next;
      rd_valid <= rd_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    n          <= n_next;
    k          <= k_next;
    radix_held <= radix_held_next;
    rd_last    <= rd_last_next;
    rd_count   <= rd_count_next;
  end

  // result word comes straight off the store's read register
  assign strobe             = rd_valid;
  assign result.digit_char  = digit_to_ascii(st_rd_data);
  assign result.digit_count = rd_count;
  assign result.last        = rd_last;

endmodule
